### rtl/core/crossed_string_view_factor_defines.svh
// Assertion macros shared by the checker of the crossed-string view factor block.
`ifndef CROSSED_STRING_VIEW_FACTOR_DEFINES_SVH
`define CROSSED_STRING_VIEW_FACTOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define CSVF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csvf assertion failed");

// Clocked assertion that also holds across reset.
`define CSVF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("csvf assertion failed");

`endif

### rtl/core/csvf_pkg.sv
// Shared constants and types of the crossed-string view factor block.
package csvf_pkg;

  localparam int FIELD_W  = 32;
  localparam int LEN_FRAC = 13;
  localparam int VF_W     = 32;
  localparam int Q_BITS   = 31;

  localparam logic [VF_W-1:0] VF_MAX = 32'h7FFF_FFFF;
  localparam logic [VF_W-1:0] VF_MIN = 32'h8000_0000;

  // Result carried from the quotient unit to the output stage.
  typedef struct packed {
    logic [VF_W-1:0] vf;
    logic            degen;
  } vf_res_t;

endpackage

### rtl/core/csvf_dist2.sv
// Squared distance between two points, scaled for the square root, in four stages.
module csvf_dist2 #(
  parameter int COORD_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [COORD_BITS-1:0]                         a_x,
  input  logic [COORD_BITS-1:0]                         a_y,
  input  logic [COORD_BITS-1:0]                         b_x,
  input  logic [COORD_BITS-1:0]                         b_y,
  output logic [2*(COORD_BITS+csvf_pkg::LEN_FRAC+1)-1:0] rad
);
  import csvf_pkg::*;

  localparam int MW   = COORD_BITS + 1;
  localparam int LO   = MW / 2;
  localparam int HI   = MW - LO;
  localparam int SQ_W = 2 * MW;

  logic signed [MW-1:0] dx, dy;
  logic [MW-1:0]        magx_nxt, magy_nxt, magx_r, magy_r;
  logic [2*HI-1:0]      hhx_r, hhy_r;
  logic [HI+LO-1:0]     hlx_r, hly_r;
  logic [2*LO-1:0]      llx_r, lly_r;
  logic [SQ_W-1:0]      sqx_nxt, sqy_nxt, sqx_r, sqy_r;
  logic [SQ_W-1:0]      sum_nxt, sum_r;

  // Stage 1: coordinate differences and their magnitudes.
  assign dx = $signed({b_x[COORD_BITS-1], b_x}) - $signed({a_x[COORD_BITS-1], a_x});
  assign dy = $signed({b_y[COORD_BITS-1], b_y}) - $signed({a_y[COORD_BITS-1], a_y});
  assign magx_nxt = dx[MW-1] ? MW'(-dx) : MW'(dx);
  assign magy_nxt = dy[MW-1] ? MW'(-dy) : MW'(dy);

  // Stage 3: partial products recombined into the squares.
  assign sqx_nxt = (SQ_W'(hhx_r) << (2*LO)) + (SQ_W'(hlx_r) << (LO+1)) + SQ_W'(llx_r);
  assign sqy_nxt = (SQ_W'(hhy_r) << (2*LO)) + (SQ_W'(hly_r) << (LO+1)) + SQ_W'(lly_r);

  // Stage 4: sum of squares; the sum stays below twice the square of 2^COORD_BITS.
  assign sum_nxt = sqx_r + sqy_r;
  assign rad = {sum_r, {(2*LEN_FRAC){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      magx_r <= magx_nxt;
      magy_r <= magy_nxt;
      // Stage 2: half-width partial products.
      hhx_r  <= magx_r[MW-1:LO] * magx_r[MW-1:LO];
      hlx_r  <= magx_r[MW-1:LO] * magx_r[LO-1:0];
      llx_r  <= magx_r[LO-1:0] * magx_r[LO-1:0];
      hhy_r  <= magy_r[MW-1:LO] * magy_r[MW-1:LO];
      hly_r  <= magy_r[MW-1:LO] * magy_r[LO-1:0];
      lly_r  <= magy_r[LO-1:0] * magy_r[LO-1:0];
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

### rtl/core/csvf_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module csvf_isqrt #(
  parameter int RW = 46
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);
  import csvf_pkg::*;

  logic [2*RW-1:0] rad_r  [RW-1];
  logic [RW+1:0]   rem_r  [RW-1];
  logic [RW-1:0]   root_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [2*RW-1:0] rad_p;
    logic [RW+1:0]   rem_p;
    logic [RW-1:0]   root_p;
    logic [RW+1:0]   rem_s, trial, rem_nxt;
    logic            ge;

    if (k == 0) begin : g_first
      assign rad_p  = rad;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end

    // Bring down the next bit pair and try the next root bit.
    assign rem_s   = {rem_p[RW-1:0], rad_p[2*RW-1 -: 2]};
    assign trial   = {root_p, 2'b01};
    assign ge      = (rem_s >= trial);
    assign rem_nxt = ge ? (rem_s - trial) : rem_s;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_p[RW-2:0], ge};
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k] <= rad_p << 2;
          rem_r[k] <= rem_nxt;
        end
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

### rtl/core/csvf_quot.sv
// String sums, signed difference and pipelined restoring division into Q2.29.
module csvf_quot #(
  parameter int RW = 46
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [RW-1:0]              len_i,
  input  logic [RW-1:0]              cr_a,
  input  logic [RW-1:0]              cr_b,
  input  logic [RW-1:0]              un_a,
  input  logic [RW-1:0]              un_b,
  output csvf_pkg::vf_res_t          res
);
  import csvf_pkg::*;

  localparam int DW = RW + 2;

  logic [RW:0]   crs_r, uns_r, mag_b_r, mag_c_r;
  logic [RW-1:0] lia_r, lib_r, lic_r;
  logic          neg_b_r, dg_b_r, neg_c_r, dg_c_r, sat_c_r;
  logic [RW:0]   mag_b_nxt;
  logic          neg_b_nxt;

  logic [DW-1:0]     r_r   [Q_BITS];
  logic [Q_BITS-1:0] q_r   [Q_BITS];
  logic [RW-1:0]     li_r  [Q_BITS];
  logic              neg_r [Q_BITS];
  logic              sat_r [Q_BITS];
  logic              dg_r  [Q_BITS];

  vf_res_t           res_nxt, res_r;
  logic [VF_W-1:0]   qx;

  // Stage B: sign and magnitude of crossed minus uncrossed.
  assign neg_b_nxt = (crs_r < uns_r);
  assign mag_b_nxt = neg_b_nxt ? (uns_r - crs_r) : (crs_r - uns_r);

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage A: the two string sums.
      crs_r   <= {1'b0, cr_a} + {1'b0, cr_b};
      uns_r   <= {1'b0, un_a} + {1'b0, un_b};
      lia_r   <= len_i;
      neg_b_r <= neg_b_nxt;
      mag_b_r <= mag_b_nxt;
      lib_r   <= lia_r;
      dg_b_r  <= (lia_r == '0);
      // Stage C: quotient of four or more saturates.
      sat_c_r <= ({1'b0, mag_b_r} >= {lib_r, 2'b00});
      mag_c_r <= mag_b_r;
      lic_r   <= lib_r;
      neg_c_r <= neg_b_r;
      dg_c_r  <= dg_b_r;
    end
  end

  // Division steps: two integer bits, then 29 fraction bits.
  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    logic [DW-1:0]     r_p, r_s, d, r_nxt;
    logic [Q_BITS-1:0] q_p;
    logic [RW-1:0]     li_p;
    logic              neg_p, sat_p, dg_p, ge;

    if (k == 0) begin : g_first
      assign r_p   = DW'(mag_c_r);
      assign q_p   = '0;
      assign li_p  = lic_r;
      assign neg_p = neg_c_r;
      assign sat_p = sat_c_r;
      assign dg_p  = dg_c_r;
    end else begin : g_next
      assign r_p   = r_r[k-1];
      assign q_p   = q_r[k-1];
      assign li_p  = li_r[k-1];
      assign neg_p = neg_r[k-1];
      assign sat_p = sat_r[k-1];
      assign dg_p  = dg_r[k-1];
    end

    if (k == 0) begin : g_two
      assign r_s = r_p;
      assign d   = DW'({li_p, 1'b0});
    end else if (k == 1) begin : g_one
      assign r_s = r_p;
      assign d   = DW'(li_p);
    end else begin : g_frac
      assign r_s = r_p << 1;
      assign d   = DW'(li_p);
    end

    assign ge    = (r_s >= d);
    assign r_nxt = ge ? (r_s - d) : r_s;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= r_nxt;
        q_r[k]   <= {q_p[Q_BITS-2:0], ge};
        li_r[k]  <= li_p;
        neg_r[k] <= neg_p;
        sat_r[k] <= sat_p;
        dg_r[k]  <= dg_p;
      end
    end
  end

  // Final stage: sign, saturation and the zero-length case.
  assign qx = {1'b0, q_r[Q_BITS-1]};

  always_comb begin
    res_nxt.degen = dg_r[Q_BITS-1];
    if (dg_r[Q_BITS-1]) begin
      res_nxt.vf = '0;
    end else if (sat_r[Q_BITS-1]) begin
      res_nxt.vf = neg_r[Q_BITS-1] ? VF_MIN : VF_MAX;
    end else begin
      res_nxt.vf = neg_r[Q_BITS-1] ? (~qx + 1'b1) : qx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### rtl/core/crossed_string_view_factor.sv
// The pipeline grows with COORD_BITS through one square-root stage per length bit.
// Throughput: one beat per cycle unless the skid entry is full; all five lengths and
// the divider are fully pipelined. A two-entry output stage holds results while
// out_tready is low; in_tready drops only when both entries are full.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module crossed_string_view_factor #(
  parameter int COORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // Fields from bit 0 up: i_start_x, i_start_y, i_end_x, i_end_y,
  // j_start_x, j_start_y, j_end_x, j_end_y (32 bits each).
  input  logic [255:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // Field from bit 0 up: view_factor (32 bits).
  output logic [31:0]   out_tdata,
  // Field from bit 0 up: degenerate (1 bit).
  output logic [0:0]    out_tuser
);
  import csvf_pkg::*;

  localparam int RW   = COORD_BITS + LEN_FRAC + 1;
  localparam int LAT  = 4 + RW + 3 + Q_BITS + 1;
  localparam int EXTW = FIELD_W + COORD_BITS;

  logic                  adv;
  logic [LAT-1:0]        vld_r;
  logic [COORD_BITS-1:0] crd [8];
  logic [2*RW-1:0]       rad [5];
  logic [RW-1:0]         len [5];
  vf_res_t               res, out_r, skid_r;
  logic                  out_vld_r, skid_full_r;

  // Coordinates are the low COORD_BITS bits of each zero-extended field.
  for (genvar f = 0; f < 8; f++) begin : g_crd
    logic [EXTW-1:0] ext;
    assign ext    = {{COORD_BITS{1'b0}}, in_tdata[f*FIELD_W +: FIELD_W]};
    assign crd[f] = ext[COORD_BITS-1:0];
  end

  // The whole pipeline moves unless the output skid entry is full.
  assign adv       = !skid_full_r;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Five point pairs: length of i, two crossed and two uncrossed strings.
  csvf_dist2 #(.COORD_BITS(COORD_BITS)) u_d_li (.clk, .en(adv),
    .a_x(crd[0]), .a_y(crd[1]), .b_x(crd[2]), .b_y(crd[3]), .rad(rad[0]));
  csvf_dist2 #(.COORD_BITS(COORD_BITS)) u_d_c1 (.clk, .en(adv),
    .a_x(crd[0]), .a_y(crd[1]), .b_x(crd[4]), .b_y(crd[5]), .rad(rad[1]));
  csvf_dist2 #(.COORD_BITS(COORD_BITS)) u_d_c2 (.clk, .en(adv),
    .a_x(crd[2]), .a_y(crd[3]), .b_x(crd[6]), .b_y(crd[7]), .rad(rad[2]));
  csvf_dist2 #(.COORD_BITS(COORD_BITS)) u_d_u1 (.clk, .en(adv),
    .a_x(crd[2]), .a_y(crd[3]), .b_x(crd[4]), .b_y(crd[5]), .rad(rad[3]));
  csvf_dist2 #(.COORD_BITS(COORD_BITS)) u_d_u2 (.clk, .en(adv),
    .a_x(crd[0]), .a_y(crd[1]), .b_x(crd[6]), .b_y(crd[7]), .rad(rad[4]));

  for (genvar s = 0; s < 5; s++) begin : g_sqrt
    csvf_isqrt #(.RW(RW)) u_sqrt (.clk, .en(adv), .rad(rad[s]), .root(len[s]));
  end

  csvf_quot #(.RW(RW)) u_quot (
    .clk,
    .en    (adv),
    .len_i (len[0]),
    .cr_a  (len[1]),
    .cr_b  (len[2]),
    .un_a  (len[3]),
    .un_b  (len[4]),
    .res   (res)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (skid_full_r) begin
        out_vld_r   <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_vld_r <= vld_r[LAT-1];
      end
    end else if (adv && vld_r[LAT-1]) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_tready) begin
      out_r <= skid_full_r ? skid_r : res;
    end else if (adv && vld_r[LAT-1]) begin
      skid_r <= res;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_r.vf;
  assign out_tuser[0] = out_r.degen;

endmodule

### rtl/core/csvf_checker.sv
// Port-level checks of the crossed-string view factor block, bound to the top level.
`include "crossed_string_view_factor_defines.svh"

module csvf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);
  import csvf_pkg::*;

  // A held output beat stays valid until taken.
  `CSVF_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> out_tvalid)

  // A degenerate beat always carries a zero factor.
  `CSVF_ASSERT(a_degen_zero, clk, rst_n, (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))

  // Input back-pressure only happens while an output beat is waiting.
  `CSVF_ASSERT(a_stall_cause, clk, rst_n, !in_tready |-> out_tvalid)

  // Reset empties the output.
  `CSVF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)

endmodule

bind crossed_string_view_factor csvf_checker u_csvf_checker (.*);
